// ===== sv/heightmap_normal_stream_core_macros.svh =====
// Assertion macros shared by the heightmap normal stream RTL.
`ifndef HEIGHTMAP_NORMAL_STREAM_CORE_MACROS_SVH
`define HEIGHTMAP_NORMAL_STREAM_CORE_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define HNS_ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// Check that a condition implies another in the same cycle.
`define HNS_ASSERT_IMPLIES(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) else $error(msg);

`endif

// ===== sv/hns_pkg.sv =====
// Types, constants and register codes of the heightmap normal stream core.
package hns_pkg;

	localparam int MAX_RES   = 256;
	localparam int RES_W     = 9;
	localparam int COORD_W   = $clog2(MAX_RES);
	localparam int HEIGHT_W  = 16;
	localparam int DIFF_W    = HEIGHT_W + 1;
	localparam int SCALE_W   = 16;
	localparam int ADDR_W    = 3;
	localparam int DATA_W    = 32;

	localparam logic [RES_W-1:0]   RES_RESET   = RES_W'(64);
	localparam logic [RES_W-1:0]   RES_MIN     = RES_W'(2);
	localparam logic [RES_W-1:0]   RES_MAX     = RES_W'(MAX_RES);
	localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(256);

	// register index codes (byte address bit 2)
	localparam logic [0:0] REG_RESOLUTION   = 1'b0;
	localparam logic [0:0] REG_HEIGHT_SCALE = 1'b1;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// back-end arithmetic
	localparam int PROD_W     = DIFF_W + SCALE_W + 1;
	localparam int MAG_W      = PROD_W - 1;
	localparam int NORM_W     = 30;
	localparam int SQ_W       = 2 * NORM_W;
	localparam int SUM_W      = SQ_W + 2;
	localparam int ROOT_W     = SUM_W + 1;
	localparam int ROOT_STEPS = ROOT_W / 2 + 1;
	localparam int CNT_W      = $clog2(ROOT_STEPS);
	localparam int RQ_W       = 32;
	localparam int FRAC_W     = 14;
	localparam int Q_W        = 15;
	localparam int NUM_W      = NORM_W + FRAC_W + 1;
	localparam int LANES      = 3;

	localparam logic [MAG_W-1:0]  TWO_FIXED = MAG_W'(131072);
	localparam logic [MAG_W-1:0]  NORM_LO   = MAG_W'(1) << (NORM_W - 1);
	localparam logic [MAG_W-1:0]  NORM_HI   = MAG_W'(1) << NORM_W;
	localparam logic [ROOT_W-1:0] ROOT_BIT0 = ROOT_W'(1) << (ROOT_W - 1);
	localparam logic [Q_W-1:0]    ONE_Q14   = Q_W'(16384);

	typedef struct packed {
		logic signed [HEIGHT_W-1:0] height;
		logic                       frame_start;
	} pix_t;

	typedef struct packed {
		logic signed [15:0]  normal_x;
		logic signed [15:0]  normal_y;
		logic [Q_W-1:0]      normal_z;
		logic [COORD_W-1:0]  column;
		logic [COORD_W-1:0]  row;
		logic                last_of_run;
		logic                last_of_map;
	} nrm_t;

	// one normal to compute: gradient differences and pixel tags
	typedef struct packed {
		logic signed [DIFF_W-1:0] da;
		logic signed [DIFF_W-1:0] db;
		logic [COORD_W-1:0]       column;
		logic [COORD_W-1:0]       row;
		logic                     last_of_run;
		logic                     last_of_map;
	} job_t;

endpackage

// ===== sv/hns_ram.sv =====
// Generic RAM: one write port, two registered read ports.
module hns_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	output logic [WIDTH-1:0]         rdata_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

// ===== sv/hns_front.sv =====
// Front end: accepts height samples, tracks position, reads row stores, builds jobs.
module hns_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [hns_pkg::RES_W-1:0]   resolution,
	input  logic                        pix_valid,
	output logic                        pix_stall,
	input  hns_pkg::pix_t               pix,
	output logic                        push,
	output hns_pkg::job_t               job,
	input  logic                        full
);

	typedef enum logic [1:0] {F_IDLE, F_READ, F_EMIT} fstate_t;

	fstate_t                             state_q;
	logic [hns_pkg::COORD_W-1:0]         colcnt_q, rowcnt_q, x_q, y_q;
	logic signed [hns_pkg::HEIGHT_W-1:0] h_q, rec0_q, rec1_q;
	hns_pkg::job_t                       jobs_q [3];
	logic [2:0]                          pend_q;

	logic [hns_pkg::RES_W-1:0]           res_eff, x9, y9, nx9, ny9;
	logic                                accept, restart;
	logic [hns_pkg::COORD_W-1:0]         x_new, y_new;
	logic [hns_pkg::HEIGHT_W-1:0]        prev_c, prev_r, sec_l, sec_d;
	logic signed [hns_pkg::HEIGHT_W-1:0] c, left1, right1, down1, left2;
	logic                                en1, en2, en3, ylast;
	hns_pkg::job_t                       j1, j2, j3;
	logic [2:0]                          pend_next;

	function automatic logic signed [hns_pkg::DIFF_W-1:0] hdiff(
		input logic signed [hns_pkg::HEIGHT_W-1:0] a,
		input logic signed [hns_pkg::HEIGHT_W-1:0] b
	);
		hdiff = hns_pkg::DIFF_W'(a) - hns_pkg::DIFF_W'(b);
	endfunction

	always_comb begin
		if (resolution < hns_pkg::RES_MIN) begin
			res_eff = hns_pkg::RES_MIN;
		end else if (resolution > hns_pkg::RES_MAX) begin
			res_eff = hns_pkg::RES_MAX;
		end else begin
			res_eff = resolution;
		end
	end

	assign pix_stall = (state_q != F_IDLE);
	assign accept    = pix_valid && !pix_stall;
	assign restart   = pix.frame_start || ({1'b0, colcnt_q} >= res_eff)
		|| ({1'b0, rowcnt_q} >= res_eff);
	assign x_new     = restart ? '0 : colcnt_q;
	assign y_new     = restart ? '0 : rowcnt_q;

	// row above (previous) and two rows above (second previous)
	hns_ram #(.WIDTH(hns_pkg::HEIGHT_W), .DEPTH(hns_pkg::MAX_RES)) u_prev (
		.clk     (clk),
		.we      (state_q == F_READ),
		.waddr   (x_q),
		.wdata   (h_q),
		.raddr_a (x_new),
		.rdata_a (prev_c),
		.raddr_b (x_new + hns_pkg::COORD_W'(1)),
		.rdata_b (prev_r)
	);

	hns_ram #(.WIDTH(hns_pkg::HEIGHT_W), .DEPTH(hns_pkg::MAX_RES)) u_sec (
		.clk     (clk),
		.we      (state_q == F_READ),
		.waddr   (x_q),
		.wdata   (prev_c),
		.raddr_a (x_new - hns_pkg::COORD_W'(1)),
		.rdata_a (sec_l),
		.raddr_b (x_new),
		.rdata_b (sec_d)
	);

	always_comb begin
		x9     = {1'b0, x_q};
		y9     = {1'b0, y_q};
		nx9    = x9 + hns_pkg::RES_W'(1);
		ny9    = y9 + hns_pkg::RES_W'(1);
		c      = $signed(prev_c);
		ylast  = (ny9 == res_eff);
		en1    = (y_q != '0);
		en2    = ylast && (x_q != '0);
		en3    = ylast && (nx9 == res_eff);
		left1  = (x_q != '0) ? $signed(sec_l) : c;
		right1 = (nx9 < res_eff) ? $signed(prev_r) : c;
		down1  = (y_q > hns_pkg::COORD_W'(1)) ? $signed(sec_d) : c;
		left2  = (x_q > hns_pkg::COORD_W'(1)) ? rec1_q : rec0_q;

		j1.da          = hdiff(right1, left1);
		j1.db          = hdiff(h_q, down1);
		j1.column      = x_q;
		j1.row         = y_q - hns_pkg::COORD_W'(1);
		j1.last_of_run = !en2 && !en3;
		j1.last_of_map = 1'b0;

		j2.da          = hdiff(h_q, left2);
		j2.db          = hdiff(rec0_q, $signed(sec_l));
		j2.column      = x_q - hns_pkg::COORD_W'(1);
		j2.row         = y_q;
		j2.last_of_run = !en3;
		j2.last_of_map = 1'b0;

		j3.da          = hdiff(h_q, rec0_q);
		j3.db          = hdiff(h_q, c);
		j3.column      = x_q;
		j3.row         = y_q;
		j3.last_of_run = 1'b1;
		j3.last_of_map = 1'b1;
	end

	// hand out pending jobs lowest first
	always_comb begin
		if (pend_q[0]) begin
			job = jobs_q[0];
		end else if (pend_q[1]) begin
			job = jobs_q[1];
		end else begin
			job = jobs_q[2];
		end
		push      = (state_q == F_EMIT) && (pend_q != '0) && !full;
		pend_next = push ? (pend_q & (pend_q - 3'd1)) : pend_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= F_IDLE;
			colcnt_q <= '0;
			rowcnt_q <= '0;
			rec0_q   <= '0;
			rec1_q   <= '0;
			pend_q   <= '0;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (accept) begin
						state_q <= F_READ;
					end
				end
				F_READ: begin
					pend_q <= {en3, en2, en1};
					rec1_q <= rec0_q;
					rec0_q <= h_q;
					if (nx9 >= res_eff) begin
						colcnt_q <= '0;
						rowcnt_q <= (ny9 >= res_eff) ? '0 : ny9[hns_pkg::COORD_W-1:0];
					end else begin
						colcnt_q <= nx9[hns_pkg::COORD_W-1:0];
						rowcnt_q <= y_q;
					end
					state_q <= F_EMIT;
				end
				F_EMIT: begin
					pend_q <= pend_next;
					if (pend_next == '0) begin
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_q <= x_new;
			y_q <= y_new;
			h_q <= pix.height;
		end
		if (state_q == F_READ) begin
			jobs_q[0] <= j1;
			jobs_q[1] <= j2;
			jobs_q[2] <= j3;
		end
	end

endmodule

// ===== sv/hns_fifo.sv =====
// Short job queue between front and back ends.
`include "heightmap_normal_stream_core_macros.svh"
module hns_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  hns_pkg::job_t din,
	output logic          full,
	input  logic          pop,
	output hns_pkg::job_t dout,
	output logic          empty
);

	hns_pkg::job_t               entries_q [hns_pkg::QUEUE_DEPTH];
	logic [hns_pkg::QPTR_W-1:0]  wr_q, rd_q;
	logic [hns_pkg::QCNT_W-1:0]  count_q;

	function automatic logic [hns_pkg::QPTR_W-1:0] bump(input logic [hns_pkg::QPTR_W-1:0] p);
		bump = (p == hns_pkg::QPTR_W'(hns_pkg::QUEUE_DEPTH - 1)) ? '0 : p + hns_pkg::QPTR_W'(1);
	endfunction

	assign full  = (count_q == hns_pkg::QCNT_W'(hns_pkg::QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign dout  = entries_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= bump(wr_q);
			end
			if (pop) begin
				rd_q <= bump(rd_q);
			end
			if (push && !pop) begin
				count_q <= count_q + hns_pkg::QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - hns_pkg::QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_q] <= din;
		end
	end

	`HNS_ASSERT_IMPLIES(a_no_overflow, push, !full, "job queue written while full")
	`HNS_ASSERT_IMPLIES(a_no_underflow, pop, !empty, "job queue read while empty")

endmodule

// ===== sv/hns_back.sv =====
// Back end: scales gradients, normalizes, takes the root and divides serially.
`include "heightmap_normal_stream_core_macros.svh"
module hns_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [hns_pkg::SCALE_W-1:0]   height_scale,
	input  hns_pkg::job_t                 job,
	input  logic                          empty,
	output logic                          pop,
	output logic                          nrm_valid,
	input  logic                          nrm_stall,
	output hns_pkg::nrm_t                 nrm
);

	typedef enum logic [2:0] {
		B_IDLE, B_MULA, B_MULB, B_NORM, B_SQ, B_ROOT, B_DSET, B_DIV
	} bstate_t;

	bstate_t                      state_q;
	logic                         out_pend_q;
	logic [hns_pkg::CNT_W-1:0]    cnt_q;
	hns_pkg::job_t                job_q;
	logic                         sa_q, sb_q;
	logic [hns_pkg::MAG_W-1:0]    mag_q [hns_pkg::LANES];
	logic [hns_pkg::MAG_W-1:0]    m_q;
	logic [hns_pkg::SUM_W-1:0]    rn_q;
	logic [hns_pkg::ROOT_W-1:0]   rres_q, rbit_q;
	logic [hns_pkg::RQ_W-1:0]     rr_q;
	logic [hns_pkg::RQ_W-1:0]     rem_q [hns_pkg::LANES];
	logic [hns_pkg::Q_W-1:0]      low_q [hns_pkg::LANES];
	logic [hns_pkg::Q_W-1:0]      quo_q [hns_pkg::LANES];

	logic signed [hns_pkg::DIFF_W-1:0] mul_a, scale_s;
	logic signed [hns_pkg::PROD_W-1:0] prod;
	logic [hns_pkg::MAG_W-1:0]         mag, mab, mmax;
	logic                              pos;
	logic [hns_pkg::NORM_W-1:0]        sq_op;
	logic [hns_pkg::SQ_W-1:0]          sq;
	logic [hns_pkg::ROOT_W-1:0]        rtrial;
	logic [hns_pkg::NUM_W-1:0]         num [hns_pkg::LANES];
	logic [hns_pkg::RQ_W-1:0]          dtrial [hns_pkg::LANES];
	logic                              out_free;

	// one shared multiplier for both gradients
	assign mul_a   = (state_q == B_MULA) ? job_q.da : job_q.db;
	assign scale_s = $signed({1'b0, height_scale});
	assign prod    = mul_a * scale_s;
	assign mag     = prod[hns_pkg::PROD_W-1] ? hns_pkg::MAG_W'(-prod) : prod[hns_pkg::MAG_W-1:0];
	assign pos     = !prod[hns_pkg::PROD_W-1] && (prod != '0);
	assign mab     = (mag_q[0] > mag) ? mag_q[0] : mag;
	assign mmax    = (mab > hns_pkg::TWO_FIXED) ? mab : hns_pkg::TWO_FIXED;

	always_comb begin
		case (cnt_q)
			hns_pkg::CNT_W'(0): sq_op = mag_q[0][hns_pkg::NORM_W-1:0];
			hns_pkg::CNT_W'(1): sq_op = mag_q[1][hns_pkg::NORM_W-1:0];
			default:            sq_op = mag_q[2][hns_pkg::NORM_W-1:0];
		endcase
	end
	assign sq     = sq_op * sq_op;
	assign rtrial = rres_q + rbit_q;

	always_comb begin
		for (int i = 0; i < hns_pkg::LANES; i++) begin
			num[i]    = {1'b0, mag_q[i][hns_pkg::NORM_W-1:0], hns_pkg::FRAC_W'(0)}
				+ hns_pkg::NUM_W'(rres_q >> 1);
			dtrial[i] = {rem_q[i][hns_pkg::RQ_W-2:0], low_q[i][hns_pkg::Q_W-1]};
		end
	end

	assign pop      = (state_q == B_IDLE) && !empty && !out_pend_q;
	assign out_free = !nrm_valid || !nrm_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= B_IDLE;
			cnt_q      <= '0;
			nrm_valid  <= 1'b0;
			out_pend_q <= 1'b0;
		end else begin
			// load a finished result when free, else drop the output once taken
			if (out_pend_q && out_free) begin
				nrm_valid  <= 1'b1;
				out_pend_q <= 1'b0;
			end else if (nrm_valid && !nrm_stall) begin
				nrm_valid <= 1'b0;
			end
			unique case (state_q)
				B_IDLE: begin
					if (pop) begin
						state_q <= B_MULA;
					end
				end
				B_MULA: state_q <= B_MULB;
				B_MULB: state_q <= B_NORM;
				B_NORM: begin
					if (m_q >= hns_pkg::NORM_LO && m_q < hns_pkg::NORM_HI) begin
						state_q <= B_SQ;
						cnt_q   <= '0;
					end
				end
				B_SQ: begin
					if (cnt_q == hns_pkg::CNT_W'(hns_pkg::LANES - 1)) begin
						state_q <= B_ROOT;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + hns_pkg::CNT_W'(1);
					end
				end
				B_ROOT: begin
					if (cnt_q == hns_pkg::CNT_W'(hns_pkg::ROOT_STEPS - 1)) begin
						state_q <= B_DSET;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + hns_pkg::CNT_W'(1);
					end
				end
				B_DSET: state_q <= B_DIV;
				B_DIV: begin
					if (cnt_q == hns_pkg::CNT_W'(hns_pkg::Q_W - 1)) begin
						state_q    <= B_IDLE;
						cnt_q      <= '0;
						out_pend_q <= 1'b1;
					end else begin
						cnt_q <= cnt_q + hns_pkg::CNT_W'(1);
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= job;
		end
		if (state_q == B_MULA) begin
			mag_q[0] <= mag;
			sa_q     <= pos;
		end
		if (state_q == B_MULB) begin
			mag_q[1] <= mag;
			sb_q     <= pos;
			mag_q[2] <= hns_pkg::TWO_FIXED;
			m_q      <= mmax;
			rn_q     <= '0;
		end
		// shift all three until the largest sits at bit 29
		if (state_q == B_NORM) begin
			if (m_q < hns_pkg::NORM_LO) begin
				m_q <= m_q << 1;
				for (int i = 0; i < hns_pkg::LANES; i++) begin
					mag_q[i] <= mag_q[i] << 1;
				end
			end else if (m_q >= hns_pkg::NORM_HI) begin
				m_q <= m_q >> 1;
				for (int i = 0; i < hns_pkg::LANES; i++) begin
					mag_q[i] <= mag_q[i] >> 1;
				end
			end
		end
		if (state_q == B_SQ) begin
			rn_q <= rn_q + hns_pkg::SUM_W'(sq);
			if (cnt_q == hns_pkg::CNT_W'(hns_pkg::LANES - 1)) begin
				rres_q <= '0;
				rbit_q <= hns_pkg::ROOT_BIT0;
			end
		end
		// one result bit of the square root per cycle
		if (state_q == B_ROOT) begin
			if ({1'b0, rn_q} >= rtrial) begin
				rn_q   <= rn_q - hns_pkg::SUM_W'(rtrial);
				rres_q <= (rres_q >> 1) + rbit_q;
			end else begin
				rres_q <= rres_q >> 1;
			end
			rbit_q <= rbit_q >> 2;
		end
		if (state_q == B_DSET) begin
			rr_q <= hns_pkg::RQ_W'(rres_q);
			for (int i = 0; i < hns_pkg::LANES; i++) begin
				rem_q[i] <= hns_pkg::RQ_W'(num[i] >> hns_pkg::Q_W);
				low_q[i] <= num[i][hns_pkg::Q_W-1:0];
			end
		end
		// one quotient bit per cycle in each lane
		if (state_q == B_DIV) begin
			for (int i = 0; i < hns_pkg::LANES; i++) begin
				if (dtrial[i] >= rr_q) begin
					rem_q[i] <= dtrial[i] - rr_q;
					quo_q[i] <= {quo_q[i][hns_pkg::Q_W-2:0], 1'b1};
				end else begin
					rem_q[i] <= dtrial[i];
					quo_q[i] <= {quo_q[i][hns_pkg::Q_W-2:0], 1'b0};
				end
				low_q[i] <= low_q[i] << 1;
			end
		end
		if (out_pend_q && out_free) begin
			nrm.normal_x    <= sa_q ? -$signed({1'b0, quo_q[0]}) : $signed({1'b0, quo_q[0]});
			nrm.normal_y    <= sb_q ? -$signed({1'b0, quo_q[1]}) : $signed({1'b0, quo_q[1]});
			nrm.normal_z    <= quo_q[2];
			nrm.column      <= job_q.column;
			nrm.row         <= job_q.row;
			nrm.last_of_run <= job_q.last_of_run;
			nrm.last_of_map <= job_q.last_of_map;
		end
	end

	`HNS_ASSERT_IMPLIES(a_norm_range, state_q == B_SQ,
		m_q >= hns_pkg::NORM_LO && m_q < hns_pkg::NORM_HI, "operands not normalized")
	`HNS_ASSERT_IMPLIES(a_root_floor, state_q == B_DIV,
		rr_q >= hns_pkg::RQ_W'(hns_pkg::NORM_LO), "root below normalized floor")
	`HNS_ASSERT_IMPLIES(a_z_unit, nrm_valid, nrm.normal_z <= hns_pkg::ONE_Q14,
		"normal z above one")

endmodule

// ===== sv/heightmap_normal_stream_core.sv =====
// The front takes an item through its read and emit states and queues 0 to 3 jobs,
// one per cycle while the queue is not full. The back end then computes each normal:
// both scaling multiplies, the normalizing shift, the squares, the serial square root,
// divider setup and the three-lane divider; it takes no new job until its result is in the output register.
// Normals of row y appear while row y+1 streams in; the last row adds extra normals.
// Reset clears counters, queue and handshakes; row stores are not cleared.
module heightmap_normal_stream_core (
	input  logic                          clk,
	input  logic                          arst_n,
	// APB configuration port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [hns_pkg::ADDR_W-1:0]    paddr,
	input  logic [hns_pkg::DATA_W-1:0]    pwdata,
	output logic [hns_pkg::DATA_W-1:0]    prdata,
	output logic                          pready,
	// height sample stream
	input  logic                          pix_valid,
	output logic                          pix_stall,
	input  hns_pkg::pix_t                 pix,
	// normal stream
	output logic                          nrm_valid,
	input  logic                          nrm_stall,
	output hns_pkg::nrm_t                 nrm
);

	logic [hns_pkg::RES_W-1:0]   resolution_q;
	logic [hns_pkg::SCALE_W-1:0] height_scale_q;
	logic                        cfg_wr;
	logic                        q_push, q_full, q_pop, q_empty;
	hns_pkg::job_t               q_din, q_dout;

	// register write on the APB access phase; pready is always high
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			resolution_q   <= hns_pkg::RES_RESET;
			height_scale_q <= hns_pkg::SCALE_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				hns_pkg::REG_RESOLUTION:   resolution_q   <= pwdata[hns_pkg::RES_W-1:0];
				hns_pkg::REG_HEIGHT_SCALE: height_scale_q <= pwdata[hns_pkg::SCALE_W-1:0];
				default:                   resolution_q   <= resolution_q;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			hns_pkg::REG_RESOLUTION:   prdata = hns_pkg::DATA_W'(resolution_q);
			hns_pkg::REG_HEIGHT_SCALE: prdata = hns_pkg::DATA_W'(height_scale_q);
			default:                   prdata = '0;
		endcase
	end

	// front: position tracking, row stores, job build
	hns_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.resolution (resolution_q),
		.pix_valid  (pix_valid),
		.pix_stall  (pix_stall),
		.pix        (pix),
		.push       (q_push),
		.job        (q_din),
		.full       (q_full)
	);

	// decouple request intake from the slow normal computation
	hns_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.din    (q_din),
		.full   (q_full),
		.pop    (q_pop),
		.dout   (q_dout),
		.empty  (q_empty)
	);

	// back: scale, normalize, root, divide, hold result in the output register
	hns_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.height_scale (height_scale_q),
		.job          (q_dout),
		.empty        (q_empty),
		.pop          (q_pop),
		.nrm_valid    (nrm_valid),
		.nrm_stall    (nrm_stall),
		.nrm          (nrm)
	);

endmodule

// ===== tb/tb_heightmap_normal_stream_core.sv =====
// Self-checking testbench for the heightmap normal stream core.
module tb_heightmap_normal_stream_core;
	import hns_pkg::*;

	localparam int CYCLE_LIMIT = 3000000;
	// settle time after the last expected normal: front plus three back-end passes
	localparam int SETTLE_CYCLES = 300;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic pready;
	logic pix_valid;
	logic pix_stall;
	pix_t pix;
	logic nrm_valid;
	logic nrm_stall;
	nrm_t nrm;

	heightmap_normal_stream_core i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.pix_valid(pix_valid),
		.pix_stall(pix_stall),
		.pix(pix),
		.nrm_valid(nrm_valid),
		.nrm_stall(nrm_stall),
		.nrm(nrm)
	);

	// heights waiting to be offered, normals waiting to arrive
	pix_t heights_pending[$];
	nrm_t normals_due[$];

	int send_idle_pct;
	int recv_idle_pct;
	int error_count;
	int samples_taken;
	int normals_checked;
	int maps_sent;
	int cycle_count;

	// predictor state: configuration as written, row stores, position
	int cfg_res;
	int cfg_scale;
	int prev_row[MAX_RES];
	int prev2_row[MAX_RES];
	int col_pos;
	int row_pos;
	int recent0;
	int recent1;

	initial clk = 1'b0;
	always #10 clk = ~clk;

	task automatic report_mismatch(input string what);
		error_count++;
		$display("MISMATCH at cycle %0d: %s", cycle_count, what);
	endtask

	function automatic longint unsigned int_sqrt(input longint unsigned n);
		longint unsigned res;
		longint unsigned bit_w;
		res = 0;
		bit_w = 64'd1 << 62;
		while (bit_w > n)
			bit_w >>= 2;
		while (bit_w != 0) begin
			if (n >= res + bit_w) begin
				n -= res + bit_w;
				res = (res >> 1) + bit_w;
			end else begin
				res >>= 1;
			end
			bit_w >>= 2;
		end
		return res;
	endfunction

	// Normalize (-a, -b, 2) in fixed point: scale the largest magnitude to bit 29,
	// take the root of the sum of squares, then round each quotient half up.
	function automatic nrm_t unit_normal(input int lft, input int rgt, input int dn,
			input int up, input int col, input int rw, input bit last_map);
		longint a;
		longint b;
		longint unsigned ma;
		longint unsigned mb;
		longint unsigned mc;
		longint unsigned m;
		longint unsigned rt;
		longint unsigned qa;
		longint unsigned qb;
		longint unsigned qc;
		int p;
		nrm_t n;
		a = longint'(rgt - lft) * longint'(cfg_scale);
		b = longint'(up - dn) * longint'(cfg_scale);
		ma = (a < 0) ? longint'(-a) : a;
		mb = (b < 0) ? longint'(-b) : b;
		mc = 131072;
		m = mc;
		if (ma > m) m = ma;
		if (mb > m) m = mb;
		p = 0;
		while (p < 63 && (m >> (p + 1)) != 0)
			p++;
		if (p < 29) begin
			ma <<= (29 - p);
			mb <<= (29 - p);
			mc <<= (29 - p);
		end else begin
			ma >>= (p - 29);
			mb >>= (p - 29);
			mc >>= (p - 29);
		end
		rt = int_sqrt(ma * ma + mb * mb + mc * mc);
		if (rt == 0) rt = 1;
		qa = (ma * 16384 + rt / 2) / rt;
		qb = (mb * 16384 + rt / 2) / rt;
		qc = (mc * 16384 + rt / 2) / rt;
		n.normal_x = 16'((a > 0) ? -longint'(qa) : longint'(qa));
		n.normal_y = 16'((b > 0) ? -longint'(qb) : longint'(qb));
		n.normal_z = Q_W'(qc);
		n.column = COORD_W'(col);
		n.row = COORD_W'(rw);
		n.last_of_run = 1'b0;
		n.last_of_map = last_map;
		return n;
	endfunction

	// Take one accepted height and queue the normals it completes.
	task automatic advance_normal_map(input pix_t s);
		int res;
		int x;
		int y;
		int c;
		int h;
		int lft;
		int rgt;
		int dn;
		int ctr;
		int cnt;
		nrm_t outs[3];
		res = cfg_res;
		if (res < 2) res = 2;
		if (res > MAX_RES) res = MAX_RES;
		h = s.height;
		if (s.frame_start || col_pos >= res || row_pos >= res) begin
			col_pos = 0;
			row_pos = 0;
		end
		x = col_pos;
		y = row_pos;
		cnt = 0;
		c = prev_row[x];
		// the pixel one row up is now complete
		if (y > 0) begin
			lft = (x > 0) ? prev2_row[x-1] : c;
			rgt = (x + 1 < res) ? prev_row[x+1] : c;
			dn = (y > 1) ? prev2_row[x] : c;
			outs[cnt] = unit_normal(lft, rgt, dn, h, x, y - 1, 1'b0);
			cnt++;
		end
		prev2_row[x] = c;
		prev_row[x] = h;
		// last row: flush the left neighbor, and the final pixel at the corner
		if (y == res - 1) begin
			if (x > 0) begin
				ctr = recent0;
				lft = (x > 1) ? recent1 : ctr;
				dn = prev2_row[x-1];
				outs[cnt] = unit_normal(lft, h, dn, ctr, x - 1, y, 1'b0);
				cnt++;
			end
			if (x == res - 1) begin
				outs[cnt] = unit_normal(recent0, h, c, h, x, y, 1'b1);
				cnt++;
			end
		end
		recent1 = recent0;
		recent0 = h;
		col_pos = x + 1;
		if (col_pos >= res) begin
			col_pos = 0;
			row_pos = y + 1;
			if (row_pos >= res) row_pos = 0;
		end
		if (cnt > 0) outs[cnt-1].last_of_run = 1'b1;
		for (int i = 0; i < cnt; i++)
			normals_due.push_back(outs[i]);
	endtask

	// Driver: record the accepted request, then offer the next one or idle.
	always @(posedge clk) begin
		if (arst_n) begin
			if (pix_valid && !pix_stall) begin
				advance_normal_map(pix);
				samples_taken++;
			end
			// hold a stalled request; otherwise advance to the next one
			if (!pix_valid || !pix_stall) begin
				if (heights_pending.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					pix <= heights_pending.pop_front();
					pix_valid <= 1'b1;
				end else begin
					pix_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: compare each accepted normal with the oldest one due, then stall at random.
	always @(posedge clk) begin
		nrm_t want;
		if (arst_n) begin
			if (nrm_valid && !nrm_stall) begin
				if (normals_due.size() == 0) begin
					report_mismatch($sformatf("unexpected normal at (%0d,%0d)",
						nrm.column, nrm.row));
				end else begin
					want = normals_due.pop_front();
					normals_checked++;
					if (nrm.normal_x !== want.normal_x)
						report_mismatch($sformatf("normal_x %0d, want %0d at (%0d,%0d)",
							nrm.normal_x, want.normal_x, want.column, want.row));
					if (nrm.normal_y !== want.normal_y)
						report_mismatch($sformatf("normal_y %0d, want %0d at (%0d,%0d)",
							nrm.normal_y, want.normal_y, want.column, want.row));
					if (nrm.normal_z !== want.normal_z)
						report_mismatch($sformatf("normal_z %0d, want %0d at (%0d,%0d)",
							nrm.normal_z, want.normal_z, want.column, want.row));
					if (nrm.column !== want.column)
						report_mismatch($sformatf("column %0d, want %0d",
							nrm.column, want.column));
					if (nrm.row !== want.row)
						report_mismatch($sformatf("row %0d, want %0d", nrm.row, want.row));
					if (nrm.last_of_run !== want.last_of_run)
						report_mismatch($sformatf("last_of_run %0b, want %0b at (%0d,%0d)",
							nrm.last_of_run, want.last_of_run, want.column, want.row));
					if (nrm.last_of_map !== want.last_of_map)
						report_mismatch($sformatf("last_of_map %0b, want %0b at (%0d,%0d)",
							nrm.last_of_map, want.last_of_map, want.column, want.row));
				end
			end
			nrm_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// Watchdog: end a hung run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d normals still due",
				cycle_count, normals_due.size());
			$display("heightmap_normal_stream_core verification failed");
			$finish;
		end
	end

	// APB write: setup cycle, then access cycle; the register takes it at the access edge.
	task automatic reg_write(input logic [0:0] idx, input int value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'({idx, 2'b00});
		pwdata <= DATA_W'(value);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == REG_RESOLUTION)
			cfg_res = value & 32'h1FF;
		else
			cfg_scale = value & 32'hFFFF;
	endtask

	// Wait until every request went out and every normal came back, then let the
	// back end settle before touching a register.
	task automatic wait_quiet();
		while (heights_pending.size() > 0 || pix_valid || normals_due.size() > 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic int pick_height(input int style, input int prior);
		int v;
		case (style)
			0: v = $signed(16'($urandom));
			1: v = prior + $urandom_range(512) - 256;
			default: v = $urandom_range(1) ? 32767 : -32768;
		endcase
		if (v > 32767) v = 32767;
		if (v < -32768) v = -32768;
		return v;
	endfunction

	// Queue count samples of a map of side res; optionally mark the first one and
	// drop a stray frame mark mid-map now and then.
	task automatic queue_map(input int res, input int count, input int style,
			input bit mark_first, input bit noisy);
		pix_t s;
		int prior;
		prior = $signed(16'($urandom)) / 4;
		for (int i = 0; i < count; i++) begin
			prior = pick_height(style, prior);
			s.height = 16'(prior);
			s.frame_start = (i == 0) ? mark_first : (noisy && $urandom_range(99) < 3);
			heights_pending.push_back(s);
		end
		maps_sent++;
	endtask

	initial begin
		int res;
		int style;
		int rand_items;
		pix_t s;
		int corners[4];
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		pix_valid = 1'b0;
		pix = '0;
		nrm_stall = 1'b0;
		error_count = 0;
		samples_taken = 0;
		normals_checked = 0;
		maps_sent = 0;
		cycle_count = 0;
		cfg_res = RES_RESET;
		cfg_scale = SCALE_RESET;
		col_pos = 0;
		row_pos = 0;
		recent0 = 0;
		recent1 = 0;
		for (int i = 0; i < MAX_RES; i++) begin
			prev_row[i] = 0;
			prev2_row[i] = 0;
		end
		send_idle_pct = 21;
		recv_idle_pct = 72;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed: smallest map with extreme heights at unit, full and zero scale
		corners = '{32767, -32768, -32768, 32767};
		reg_write(REG_RESOLUTION, 2);
		for (int k = 0; k < 3; k++) begin
			wait_quiet();
			reg_write(REG_HEIGHT_SCALE, (k == 0) ? 256 : (k == 1) ? 65535 : 0);
			for (int i = 0; i < 4; i++) begin
				s.height = 16'(corners[(i + k) % 4]);
				s.frame_start = (i == 0);
				heights_pending.push_back(s);
			end
		end
		// resolution zero acts as two; the map wraps without a frame mark
		wait_quiet();
		reg_write(REG_RESOLUTION, 0);
		reg_write(REG_HEIGHT_SCALE, 256);
		queue_map(2, 4, 0, 1'b1, 1'b0);
		queue_map(2, 4, 2, 1'b0, 1'b0);
		// 3x3 tilted plane
		wait_quiet();
		reg_write(REG_RESOLUTION, 3);
		for (int i = 0; i < 9; i++) begin
			s.height = 16'((i % 3) * 300 - (i / 3) * 700);
			s.frame_start = (i == 0);
			heights_pending.push_back(s);
		end

		// oversized resolution acts as the maximum: one row and a bit, then lower
		// the resolution mid-map so the position restarts on its own
		wait_quiet();
		reg_write(REG_RESOLUTION, 511);
		queue_map(MAX_RES, MAX_RES + 8, 1, 1'b1, 1'b0);
		wait_quiet();
		reg_write(REG_RESOLUTION, 4);
		queue_map(4, 16, 0, 1'b0, 1'b0);
		rand_items = MAX_RES + 53;

		// random: mostly whole small maps with random content, some stray marks
		while (rand_items < 500) begin
			if (rand_items > 440) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end else if (rand_items > 380) begin
				send_idle_pct = 72;
				recv_idle_pct = 21;
			end
			wait_quiet();
			res = ($urandom_range(9) == 0) ? $urandom_range(16, 9) : $urandom_range(8, 2);
			reg_write(REG_RESOLUTION, res);
			case ($urandom_range(3))
				0: reg_write(REG_HEIGHT_SCALE, 65535);
				1: reg_write(REG_HEIGHT_SCALE, $urandom_range(1024));
				default: reg_write(REG_HEIGHT_SCALE, $urandom_range(65535));
			endcase
			for (int m = 0; m < $urandom_range(3, 1); m++) begin
				style = $urandom_range(2);
				queue_map(res, res * res, style, (m == 0) || $urandom_range(1),
					$urandom_range(4) == 0);
				rand_items += res * res;
			end
		end

		wait_quiet();
		if (normals_due.size() != 0)
			report_mismatch($sformatf("%0d normals never arrived", normals_due.size()));
		$display("covered %0d samples in %0d maps, %0d normals checked, %0d mismatches",
			samples_taken, maps_sent, normals_checked, error_count);
		$display("resolutions 0 to 511 and scales 0 to 65535 under three idle mixes");
		if (error_count == 0) begin
			$display("heightmap_normal_stream_core verification clean");
		end else begin
			$display("heightmap_normal_stream_core verification failed");
		end
		$finish;
	end

endmodule
